[rtl/owtx_pkg.sv]
// Package for the one-wire pulse-width command transmitter.
// Holds the shared codes, widths, register reset values and the result type.
// No dependencies.
package owtx_pkg;

   // Field and register widths.
   localparam int unsigned OP_W    = 2;
   localparam int unsigned VALUE_W = 8;
   localparam int unsigned TICK_W  = 10;
   localparam int unsigned IDX_W   = 4;
   localparam int unsigned CSR_A_W = 3;

   // Number of bits sent per frame; command bits above the byte go out as zeros.
   localparam int unsigned CMD_BITS = 8;

   // Item kinds carried on the request tuser.
   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 2'd0,
      OP_RAW    = 2'd1,
      OP_VOLUME = 2'd2,
      OP_STOP   = 2'd3
   } op_type;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_A_W-1:0] {
      CSR_POWER_UP  = 3'd0,
      CSR_START_LOW = 3'd1,
      CSR_LONG      = 3'd2,
      CSR_SHORT     = 3'd3,
      CSR_GUARD     = 3'd4
   } csr_idx_type;

   // Register reset values.
   localparam logic [TICK_W-1:0] POWER_UP_RST  = 10'd500;
   localparam logic [TICK_W-1:0] START_LOW_RST = 10'd4;
   localparam logic [TICK_W-1:0] LONG_RST      = 10'd3;
   localparam logic [TICK_W-1:0] SHORT_RST     = 10'd1;
   localparam logic [TICK_W-1:0] GUARD_RST     = 10'd100;

   // Command codes.
   localparam logic [VALUE_W-1:0] CMD_VOLUME_BASE = 8'hE0;
   localparam logic [VALUE_W-1:0] CMD_STOP        = 8'hFE;
   localparam logic [VALUE_W-1:0] VOLUME_MAX      = 8'd7;

   // One result item.
   typedef struct packed {
      logic volume_clamped;
      logic rejected;
      logic accepted;
      logic busy_res;
      logic line_level;
   } result_type;

endpackage

[rtl/owtx_core.sv]
// Frame sequencer of the one-wire command transmitter: configuration
// registers, line state and the per-item state update. Uses owtx_pkg.
module owtx_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [owtx_pkg::CSR_A_W-1:0]        csr_idx,
   input  logic [owtx_pkg::TICK_W-1:0]         csr_wdata,
   input  logic                                step_fire,
   input  logic [owtx_pkg::OP_W-1:0]           step_op,
   input  logic [owtx_pkg::VALUE_W-1:0]        step_value,
   output owtx_pkg::result_type                step_res
);

   typedef enum logic [2:0] {
      PH_POWERUP = 3'd0,
      PH_IDLE    = 3'd1,
      PH_START   = 3'd2,
      PH_BITHI   = 3'd3,
      PH_BITLO   = 3'd4,
      PH_GUARD   = 3'd5
   } phase_type;

   localparam int unsigned TW = owtx_pkg::TICK_W;
   localparam int unsigned IW = owtx_pkg::IDX_W;
   localparam int unsigned VW = owtx_pkg::VALUE_W;

   // Configuration registers.
   logic [TW-1:0] pwr_ff,   pwr_in;
   logic [TW-1:0] start_ff, start_in;
   logic [TW-1:0] long_ff,  long_in;
   logic [TW-1:0] short_ff, short_in;
   logic [TW-1:0] guard_ff, guard_in;

   // Sequencer state.
   phase_type     phase_ff, phase_in;
   logic [TW-1:0] count_ff, count_in;
   logic [VW-1:0] shift_ff, shift_in;
   logic [IW-1:0] bidx_ff,  bidx_in;
   logic          line_ff,  line_in;

   // A pulse length of zero counts as one tick.
   function automatic logic [TW-1:0] at_least_one(input logic [TW-1:0] v);
      at_least_one = (v == '0) ? TW'(1) : v;
   endfunction

   // Bit of the command at a given index; bits past the byte read as zero.
   function automatic logic bit_at(input logic [VW-1:0] s, input logic [IW-1:0] i);
      bit_at = (i < IW'(VW)) ? s[i[2:0]] : 1'b0;
   endfunction

   // Next state and result for a configuration write or one item.
   always_comb begin
      logic [TW-1:0]   dec;
      logic [IW:0]     nxt_idx;
      logic            cur_bit;
      logic [VW-1:0]   vol;
      logic [VW-1:0]   cmd;
      logic            clamp;
      logic            acc;
      logic            rej;

      pwr_in   = pwr_ff;
      start_in = start_ff;
      long_in  = long_ff;
      short_in = short_ff;
      guard_in = guard_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      shift_in = shift_ff;
      bidx_in  = bidx_ff;
      line_in  = line_ff;
      dec      = (count_ff != '0) ? count_ff - TW'(1) : '0;
      nxt_idx  = {1'b0, bidx_ff} + (IW+1)'(1);
      cur_bit  = 1'b0;
      vol      = step_value;
      cmd      = step_value;
      clamp    = 1'b0;
      acc      = 1'b0;
      rej      = 1'b0;

      if (csr_we) begin
         unique case (csr_idx)
            owtx_pkg::CSR_POWER_UP: begin
               pwr_in = csr_wdata;
               if (phase_ff == PH_POWERUP) begin
                  count_in = csr_wdata;
                  // A zero wait ends the power-up phase at once.
                  if (csr_wdata == '0) begin
                     phase_in = PH_IDLE;
                     line_in  = 1'b1;
                  end
               end
            end
            owtx_pkg::CSR_START_LOW: start_in = csr_wdata;
            owtx_pkg::CSR_LONG:      long_in  = csr_wdata;
            owtx_pkg::CSR_SHORT:     short_in = csr_wdata;
            owtx_pkg::CSR_GUARD:     guard_in = csr_wdata;
            default: ;
         endcase
      end else if (step_fire) begin
         if (step_op == owtx_pkg::OP_TICK) begin
            // A tick counts down; at zero the frame moves to its next part.
            if (phase_ff != PH_IDLE) begin
               count_in = dec;
               if (dec == '0) begin
                  unique case (phase_ff)
                     PH_START: begin
                        bidx_in  = '0;
                        cur_bit  = shift_ff[0];
                        phase_in = PH_BITHI;
                        line_in  = 1'b1;
                        count_in = at_least_one(cur_bit ? long_ff : short_ff);
                     end
                     PH_BITHI: begin
                        cur_bit  = bit_at(shift_ff, bidx_ff);
                        phase_in = PH_BITLO;
                        line_in  = 1'b0;
                        count_in = at_least_one(cur_bit ? short_ff : long_ff);
                     end
                     PH_BITLO: begin
                        if (nxt_idx >= (IW+1)'(owtx_pkg::CMD_BITS)) begin
                           line_in  = 1'b1;
                           count_in = guard_ff;
                           phase_in = (guard_ff == '0) ? PH_IDLE : PH_GUARD;
                        end else begin
                           bidx_in  = nxt_idx[IW-1:0];
                           cur_bit  = bit_at(shift_ff, nxt_idx[IW-1:0]);
                           phase_in = PH_BITHI;
                           line_in  = 1'b1;
                           count_in = at_least_one(cur_bit ? long_ff : short_ff);
                        end
                     end
                     default: begin
                        phase_in = PH_IDLE;
                        line_in  = 1'b1;
                        count_in = '0;
                     end
                  endcase
               end
            end
         end else begin
            // Build the command byte for a request.
            if (step_value > owtx_pkg::VOLUME_MAX) begin
               vol   = owtx_pkg::VOLUME_MAX;
               clamp = (step_op == owtx_pkg::OP_VOLUME);
            end
            case (step_op)
               owtx_pkg::OP_VOLUME: cmd = owtx_pkg::CMD_VOLUME_BASE + vol;
               owtx_pkg::OP_STOP:   cmd = owtx_pkg::CMD_STOP;
               default:             cmd = step_value;
            endcase
            if (phase_ff != PH_IDLE) begin
               rej = 1'b1;
            end else begin
               acc      = 1'b1;
               shift_in = cmd;
               bidx_in  = '0;
               phase_in = PH_START;
               line_in  = 1'b0;
               count_in = at_least_one(start_ff);
            end
         end
      end

      step_res.line_level     = line_in;
      step_res.busy_res       = (phase_in != PH_IDLE);
      step_res.accepted       = acc;
      step_res.rejected       = rej;
      step_res.volume_clamped = clamp;
   end

   // State and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pwr_ff   <= owtx_pkg::POWER_UP_RST;
         start_ff <= owtx_pkg::START_LOW_RST;
         long_ff  <= owtx_pkg::LONG_RST;
         short_ff <= owtx_pkg::SHORT_RST;
         guard_ff <= owtx_pkg::GUARD_RST;
         phase_ff <= PH_POWERUP;
         count_ff <= owtx_pkg::POWER_UP_RST;
         shift_ff <= '0;
         bidx_ff  <= '0;
         line_ff  <= 1'b1;
      end else begin
         pwr_ff   <= pwr_in;
         start_ff <= start_in;
         long_ff  <= long_in;
         short_ff <= short_in;
         guard_ff <= guard_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         shift_ff <= shift_in;
         bidx_ff  <= bidx_in;
         line_ff  <= line_in;
      end
   end

   // A request is either taken or dropped, never both.
   a_acc_rej_excl : assert property (@(posedge clock) disable iff (reset)
      step_fire |-> !(step_res.accepted && step_res.rejected))
      else $error("request both accepted and rejected");

   // A taken request starts a frame with the line pulled low.
   a_start_low : assert property (@(posedge clock) disable iff (reset)
      (step_fire && !csr_we && step_res.accepted) |=> (!line_ff && phase_ff == PH_START))
      else $error("accepted request did not start a low start pulse");

   // A tick while idle leaves the sequencer idle with the line high.
   a_idle_tick : assert property (@(posedge clock) disable iff (reset)
      (step_fire && !csr_we && step_op == owtx_pkg::OP_TICK && phase_ff == PH_IDLE)
      |=> (phase_ff == PH_IDLE && line_ff))
      else $error("tick while idle changed the sequencer");

   // The line is low only during the start pulse and the low part of a bit.
   a_line_low : assert property (@(posedge clock) disable iff (reset)
      !line_ff |-> (phase_ff == PH_START || phase_ff == PH_BITLO))
      else $error("line low outside start pulse or bit low part");

endmodule

[rtl/owtx_out_buf.sv]
// Two-entry result buffer of the one-wire command transmitter: an output
// register with a skid stage. Uses owtx_pkg.
module owtx_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  owtx_pkg::result_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output owtx_pkg::result_type out_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   owtx_pkg::result_type main_data_ff,  main_data_in;
   owtx_pkg::result_type skid_data_ff,  skid_data_in;
   logic                 push;
   logic                 pop;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   // Fill the output register first, the skid stage only when it is held.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_valid_in = 1'b1;
            main_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   // The skid stage holds a result only behind a held output register.
   a_skid_order : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid stage full while output register empty");

   // A held result leaves the skid stage as soon as the output moves.
   a_skid_drain : assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> (main_valid_ff && !skid_valid_ff))
      else $error("skid stage did not drain on an output transfer");

   // Results never vanish while the output is stalled.
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && !out_ready) |=> main_valid_ff)
      else $error("result dropped while stalled");

endmodule

[rtl/one_wire_pulse_width_command_tx.sv]
// One-wire pulse-width command transmitter for a voice playback chip.
// Top level: input register, frame sequencer and result buffer. Uses owtx_pkg,
// owtx_core and owtx_out_buf.
//
// Each request item gives one result item. Time moves only with tick items
// (req_tuser = 0): after reset the block is busy for power_up_ticks ticks, an
// accepted request drives the line low for the start pulse, sends eight bits
// LSB first as high/low pulse pairs (long/short for a one, short/long for a
// zero) and then holds the line high for guard_ticks ticks. A request made
// while busy is dropped and flagged as rejected. The block takes one item per
// clock cycle while the result side keeps up; a cycle with a register write
// holds the items for that cycle. An item waits in the input register, where
// the sequencer's state update runs, and its result then waits in the output
// register until it is transferred. A two-entry output buffer lets items keep
// flowing while a result waits. Configuration writes take effect in the next
// cycle.
module one_wire_pulse_width_command_tx (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] value
   input  logic [owtx_pkg::OP_W-1:0]           req_tuser,  // [1:0] op
   // Result channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] line_level, [1] busy_res, [2] accepted, [3] rejected,
   // [4] volume_clamped, [7:5] zero
   output logic [7:0]                          rsp_tdata,
   // Configuration port.
   input  logic                                csr_we,
   input  logic [owtx_pkg::CSR_A_W-1:0]        csr_idx,
   input  logic [owtx_pkg::TICK_W-1:0]         csr_wdata
);

   logic                                in_valid_ff;
   logic [owtx_pkg::OP_W-1:0]           in_op_ff;
   logic [owtx_pkg::VALUE_W-1:0]        in_value_ff;
   logic                                buf_ready;
   logic                                step_fire;
   owtx_pkg::result_type                step_res;
   owtx_pkg::result_type                rsp_res;

   // An item moves on when the buffer has room and no register write is under way.
   assign step_fire  = in_valid_ff && buf_ready && !csr_we;
   assign req_tready = !in_valid_ff || step_fire;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_op_ff    <= req_tuser;
         in_value_ff <= req_tdata;
      end
   end

   owtx_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_idx    (csr_idx),
      .csr_wdata  (csr_wdata),
      .step_fire  (step_fire),
      .step_op    (in_op_ff),
      .step_value (in_value_ff),
      .step_res   (step_res)
   );

   owtx_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step_fire),
      .in_ready  (buf_ready),
      .in_data   (step_res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_res)
   );

   // Pack the result fields, lowest first.
   assign rsp_tdata = {3'b000, rsp_res.volume_clamped, rsp_res.rejected,
                       rsp_res.accepted, rsp_res.busy_res, rsp_res.line_level};

endmodule
